// ===== src/kta_pkg.sv =====
// shared types, codes and constants of the kseg and tlb address translator
package kta_pkg;

    localparam int TABLE_ENTRIES_DEF     = 32;
    localparam int RDRAM_OFFSET_BITS_DEF = 23;
    localparam int SP_WINDOW_BYTES_DEF   = 8192;

    // command codes
    localparam logic [1:0] CMD_TRANSLATE = 2'd0;
    localparam logic [1:0] CMD_MAP       = 2'd1;
    localparam logic [1:0] CMD_UNMAP     = 2'd2;

    // result region codes
    localparam logic [1:0] REG_RDRAM    = 2'd0;
    localparam logic [1:0] REG_SP       = 2'd1;
    localparam logic [1:0] REG_TABLE    = 2'd2;
    localparam logic [1:0] REG_FALLBACK = 2'd3;

    // job kinds handed from front to back
    localparam logic [1:0] K_WINDOW = 2'd0;
    localparam logic [1:0] K_LOOKUP = 2'd1;
    localparam logic [1:0] K_MAP    = 2'd2;
    localparam logic [1:0] K_UNMAP  = 2'd3;

    localparam logic [31:0] KSEG0_BASE   = 32'h8000_0000;
    localparam logic [31:0] KSEG1_BASE   = 32'hA000_0000;
    localparam logic [31:0] PHYS_MASK    = 32'h1FFF_FFFF;
    localparam logic [31:0] SP_BASE      = 32'h0400_0000;
    localparam logic [31:0] MASK_FLOOR   = 32'h0000_1FFF;
    localparam int          PBASE_W      = 24;
    localparam logic [63:0] FALLBACK_SUB = 64'hFFFF_FFFF_8000_0000;
    localparam int          IDX_W        = 5;
    localparam int          IDX_SPAN     = 32;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;

    typedef struct packed {
        logic [1:0]         kind;
        logic [1:0]         region;
        logic [IDX_W-1:0]   idx;
        logic [31:0]        word;    // virtual address or aligned virtual base
        logic [31:0]        size;
        logic [PBASE_W-1:0] pbase;
        logic [63:0]        offset;  // window offset or fallback offset
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// ===== src/kseg_and_tlb_address_translator.sv =====
// top level of the kseg and tlb address translator
// Address translator for kernel segments plus a fully associative translation
// table. Each input beat carries one command: translate, map an entry or unmap an
// entry (command code three is dropped at the input with no effect). A translate
// returns one result beat with a region code and a 64-bit offset; map and unmap
// return nothing. Translate checks, in order, the cached and uncached RDRAM
// windows, the SP window, the lowest-index valid table entry covering the
// address, and finally a wrapping fallback offset. The front end classifies each
// beat in the cycle it is taken and writes a job into a two-deep queue; the input
// stalls only while that queue is full. The back end drains the queue one job at
// a time: map, unmap and window hits complete when the job is popped, while a
// table lookup compares all entries in parallel into a registered hit vector,
// then picks the winner and forms the offset. Window hits and table updates go
// at one item per cycle, window hits only while the output is not stalled; no
// job is taken during a lookup or fallback. A window result goes from the queue
// head, a lookup or fallback result from the lookup registers, into the output
// register and sits there, so the queue keeps filling while it waits on a stalled
// output. No clearing pass is needed after reset: entry valid bits clear at once.
module kseg_and_tlb_address_translator #(
    parameter int TABLE_ENTRIES     = kta_pkg::TABLE_ENTRIES_DEF,
    parameter int RDRAM_OFFSET_BITS = kta_pkg::RDRAM_OFFSET_BITS_DEF,
    parameter int SP_WINDOW_BYTES   = kta_pkg::SP_WINDOW_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic [63:0] i_address,
    input  logic [4:0]  i_entry_index,
    input  logic [31:0] i_page_mask,
    input  logic [31:0] i_map_virtual,
    input  logic [31:0] i_map_physical,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_region,
    output logic [63:0] o_offset
);
    import kta_pkg::*;

    // job handoff between front and back
    logic   push;
    logic   pop;
    t_job   front_job;
    t_job   head_job;
    t_qstat qstat;

    // classify the beat and build its job
    kta_front #(
        .RDRAM_OFFSET_BITS (RDRAM_OFFSET_BITS),
        .SP_WINDOW_BYTES   (SP_WINDOW_BYTES)
    ) u_front (
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_address      (i_address),
        .i_entry_index  (i_entry_index),
        .i_page_mask    (i_page_mask),
        .i_map_virtual  (i_map_virtual),
        .i_map_physical (i_map_physical),
        .i_qstat        (qstat),
        .o_push         (push),
        .o_job          (front_job)
    );

    // decouples the two sides
    kta_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_qstat (qstat)
    );

    // table, lookup sequencing and result register
    kta_back #(
        .TABLE_ENTRIES     (TABLE_ENTRIES),
        .RDRAM_OFFSET_BITS (RDRAM_OFFSET_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (head_job),
        .i_qstat     (qstat),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_region    (o_region),
        .o_offset    (o_offset)
    );

    // sp window offsets stay inside the window
    a_sp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_region == REG_SP) |-> (o_offset < 64'(SP_WINDOW_BYTES)))
        else $error("sp offset outside window");

    // rdram and table offsets are masked to the rdram span
    a_rdram_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_region == REG_RDRAM || o_region == REG_TABLE))
            |-> ((o_offset >> RDRAM_OFFSET_BITS) == 64'd0))
        else $error("rdram offset not masked");

    // queue never pops empty or takes a push while full
    a_queue_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(pop && qstat.empty) && !(push && qstat.full))
        else $error("job queue over or underflow");

endmodule

// ===== src/kta_front.sv =====
// front end: accepts command beats and classifies them into jobs
module kta_front #(
    parameter int RDRAM_OFFSET_BITS = kta_pkg::RDRAM_OFFSET_BITS_DEF,
    parameter int SP_WINDOW_BYTES   = kta_pkg::SP_WINDOW_BYTES_DEF
) (
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic [1:0]    i_command,
    input  logic [63:0]   i_address,
    input  logic [4:0]    i_entry_index,
    input  logic [31:0]   i_page_mask,
    input  logic [31:0]   i_map_virtual,
    input  logic [31:0]   i_map_physical,
    input  kta_pkg::t_qstat i_qstat,
    output logic          o_push,
    output kta_pkg::t_job o_job
);
    import kta_pkg::*;

    localparam logic [32:0] SPAN       = 33'(1) << RDRAM_OFFSET_BITS;
    localparam logic [31:0] RDRAM_MASK = 32'((64'(1) << RDRAM_OFFSET_BITS) - 64'(1));
    localparam logic [31:0] SP_END     = SP_BASE + 32'(SP_WINDOW_BYTES);

    logic [31:0] va;
    logic [31:0] pa;
    logic        in_k0;
    logic        in_k1;
    logic        in_sp;
    logic [31:0] size_sum;
    logic [31:0] size;
    logic        cmd_ok;

    assign va    = i_address[31:0];
    assign pa    = va & PHYS_MASK;
    assign in_k0 = ({1'b0, va} >= {1'b0, KSEG0_BASE}) && ({1'b0, va} < {1'b0, KSEG0_BASE} + SPAN);
    assign in_k1 = ({1'b0, va} >= {1'b0, KSEG1_BASE}) && ({1'b0, va} < {1'b0, KSEG1_BASE} + SPAN);
    assign in_sp = (pa >= SP_BASE) && (pa < SP_END);

    // page size wraps to zero for an all-ones mask
    assign size_sum = (i_page_mask | MASK_FLOOR) + 32'd1;
    assign size     = size_sum >> 1;

    always_comb begin
        o_job        = '0;
        o_job.idx    = i_entry_index;
        cmd_ok       = 1'b1;
        unique case (i_command)
            CMD_TRANSLATE: begin
                if (in_k0 || in_k1) begin
                    o_job.kind   = K_WINDOW;
                    o_job.region = REG_RDRAM;
                    o_job.offset = {32'd0, va & RDRAM_MASK};
                end else if (in_sp) begin
                    o_job.kind   = K_WINDOW;
                    o_job.region = REG_SP;
                    o_job.offset = {32'd0, pa - SP_BASE};
                end else begin
                    o_job.kind   = K_LOOKUP;
                    o_job.region = REG_FALLBACK;
                    o_job.word   = va;
                    o_job.offset = i_address - FALLBACK_SUB;
                end
            end
            CMD_MAP: begin
                o_job.kind  = K_MAP;
                o_job.word  = i_map_virtual & ~(size - 32'd1);
                o_job.size  = size;
                o_job.pbase = i_map_physical[PBASE_W-1:0];
            end
            CMD_UNMAP: begin
                o_job.kind = K_UNMAP;
            end
            default: begin
                cmd_ok = 1'b0;
            end
        endcase
    end

    assign o_in_stall = i_qstat.full;
    assign o_push     = i_in_valid && !i_qstat.full && cmd_ok;

endmodule

// ===== src/kta_fifo.sv =====
// short job queue between front and back
module kta_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  kta_pkg::t_job i_job,
    input  logic          i_pop,
    output kta_pkg::t_job o_job,
    output kta_pkg::t_qstat o_qstat
);
    import kta_pkg::*;

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr;
    logic [Q_PTR_W-1:0] r_rd;
    logic [Q_PTR_W:0]   r_cnt;
    logic [Q_PTR_W-1:0] n_wr;
    logic [Q_PTR_W-1:0] n_rd;
    logic [Q_PTR_W:0]   n_cnt;

    assign o_job         = r_mem[r_rd];
    assign o_qstat.full  = (r_cnt == (Q_PTR_W+1)'(Q_DEPTH));
    assign o_qstat.empty = (r_cnt == '0);

    always_comb begin
        n_wr  = i_push ? Q_PTR_W'(r_wr + 1'b1) : r_wr;
        n_rd  = i_pop  ? Q_PTR_W'(r_rd + 1'b1) : r_rd;
        n_cnt = r_cnt + (Q_PTR_W+1)'(i_push) - (Q_PTR_W+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

// ===== src/kta_back.sv =====
// back end: translation table, lookup sequencer and result register
module kta_back #(
    parameter int TABLE_ENTRIES     = kta_pkg::TABLE_ENTRIES_DEF,
    parameter int RDRAM_OFFSET_BITS = kta_pkg::RDRAM_OFFSET_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  kta_pkg::t_job i_job,
    input  kta_pkg::t_qstat i_qstat,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic [1:0]    o_region,
    output logic [63:0]   o_offset
);
    import kta_pkg::*;

    localparam int          IW         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [31:0] RDRAM_MASK = 32'((64'(1) << RDRAM_OFFSET_BITS) - 64'(1));
    localparam logic        S_IDLE     = 1'b0;
    localparam logic        S_SEL      = 1'b1;

    logic [IW-1:0]            idx_mod [IDX_SPAN];
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [31:0]              r_vbase [TABLE_ENTRIES];
    logic [PBASE_W-1:0]       r_pbase [TABLE_ENTRIES];
    logic [31:0]              r_size  [TABLE_ENTRIES];

    logic                     r_state;
    logic                     n_state;
    logic [TABLE_ENTRIES-1:0] r_hit;
    logic [31:0]              r_va;
    logic [63:0]              r_fb;
    logic                     r_out_valid;
    logic                     n_out_valid;
    logic [1:0]               r_region;
    logic [1:0]               n_region;
    logic [63:0]              r_offset;
    logic [63:0]              n_offset;

    logic [TABLE_ENTRIES-1:0] hit;
    logic [IW-1:0]            widx;
    logic [IW-1:0]            sel;
    logic                     out_free;
    logic                     is_upd;
    logic                     load;
    logic [31:0]              tbl_off;

    // entry index reduced modulo table size
    for (genvar g = 0; g < IDX_SPAN; g++) begin : g_mod
        assign idx_mod[g] = IW'(g % TABLE_ENTRIES);
    end
    assign widx = idx_mod[i_job.idx];

    // every entry compared in parallel
    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            hit[i] = r_valid[i] && ((i_job.word - r_vbase[i]) < r_size[i]);
        end
    end

    // lowest index hit wins
    always_comb begin
        sel = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (r_hit[i]) begin
                sel = IW'(i);
            end
        end
    end

    assign tbl_off  = ({{(32-PBASE_W){1'b0}}, r_pbase[sel]} + (r_va - r_vbase[sel])) & RDRAM_MASK;
    assign out_free = !r_out_valid || !i_out_stall;
    assign is_upd   = (i_job.kind == K_MAP) || (i_job.kind == K_UNMAP);
    assign o_pop    = (r_state == S_IDLE) && !i_qstat.empty && (is_upd || out_free);

    always_comb begin
        n_state  = r_state;
        load     = 1'b0;
        n_region = r_region;
        n_offset = r_offset;
        unique case (r_state)
            S_IDLE: begin
                if (o_pop && i_job.kind == K_WINDOW) begin
                    load     = 1'b1;
                    n_region = i_job.region;
                    n_offset = i_job.offset;
                end else if (o_pop && i_job.kind == K_LOOKUP) begin
                    n_state = S_SEL;
                end
            end
            S_SEL: begin
                if (out_free) begin
                    load    = 1'b1;
                    n_state = S_IDLE;
                    if (|r_hit) begin
                        n_region = REG_TABLE;
                        n_offset = {32'd0, tbl_off};
                    end else begin
                        n_region = REG_FALLBACK;
                        n_offset = r_fb;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (o_pop && i_job.kind == K_MAP) begin
                r_valid[widx] <= 1'b1;
            end else if (o_pop && i_job.kind == K_UNMAP) begin
                r_valid[widx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_region <= n_region;
        r_offset <= n_offset;
        if (o_pop && i_job.kind == K_LOOKUP) begin
            r_hit <= hit;
            r_va  <= i_job.word;
            r_fb  <= i_job.offset;
        end
        if (o_pop && i_job.kind == K_MAP) begin
            r_vbase[widx] <= i_job.word;
            r_pbase[widx] <= i_job.pbase;
            r_size[widx]  <= i_job.size;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_region    = r_region;
    assign o_offset    = r_offset;

endmodule

// ===== bench/tb.sv =====
// self-checking testbench for the kseg and tlb address translator
`timescale 1ns / 100ps

module tb;
    import kta_pkg::*;

    localparam int          N_ENTRIES     = TABLE_ENTRIES_DEF;
    localparam int          RDRAM_BITS    = RDRAM_OFFSET_BITS_DEF;
    localparam int          SP_BYTES      = SP_WINDOW_BYTES_DEF;
    localparam logic [1:0]  CMD_RESERVED  = 2'd3;   // dropped by the block
    localparam logic [31:0] DEFAULT_PAGE  = 32'd4096;
    localparam int          RANDOM_BEATS  = 800;
    localparam int          SEGMENT_BEATS = 120;
    localparam int          HOLD_CYCLES   = 200;
    localparam int          DRAIN_CYCLES  = 16;

    // one translate result
    typedef struct packed {
        logic [1:0]  region;
        logic [63:0] offset;
    } t_xlat;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_command;
    logic [63:0] i_address;
    logic [4:0]  i_entry_index;
    logic [31:0] i_page_mask;
    logic [31:0] i_map_virtual;
    logic [31:0] i_map_physical;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_region;
    logic [63:0] o_offset;

    // translation table as the block should hold it
    logic        tbl_valid [N_ENTRIES];
    logic [31:0] tbl_vbase [N_ENTRIES];
    logic [23:0] tbl_pbase [N_ENTRIES];
    logic [31:0] tbl_size  [N_ENTRIES];

    // translate results still owed by the block, oldest first
    t_xlat pending_results[$];

    // idling controls shared by the sender, the receiver and the tests
    bit in_idle_en;
    bit out_idle_en;
    bit hold_out;

    int err_count;
    int n_translate;
    int n_map;
    int n_unmap;
    int n_ignored;
    int n_checked;
    int region_hits [4];

    kseg_and_tlb_address_translator u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_address      (i_address),
        .i_entry_index  (i_entry_index),
        .i_page_mask    (i_page_mask),
        .i_map_virtual  (i_map_virtual),
        .i_map_physical (i_map_physical),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_region       (o_region),
        .o_offset       (o_offset)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // expected translation of one address against the current table
    function automatic t_xlat translate_addr(input logic [63:0] addr);
        t_xlat       r;
        logic [31:0] va;
        logic [31:0] pa;
        logic [31:0] off;
        logic [63:0] va64;
        logic [63:0] span;
        va   = addr[31:0];
        va64 = {32'd0, va};
        span = 64'd1 << RDRAM_BITS;
        // direct windows, bound compared in 64 bits
        if ((va64 >= {32'd0, KSEG0_BASE} && va64 < {32'd0, KSEG0_BASE} + span) ||
            (va64 >= {32'd0, KSEG1_BASE} && va64 < {32'd0, KSEG1_BASE} + span)) begin
            r.region = REG_RDRAM;
            r.offset = va64 & (span - 64'd1);
            return r;
        end
        // sp window lives in physical space, any segment bits
        pa = va & PHYS_MASK;
        if (pa >= SP_BASE && {32'd0, pa} < {32'd0, SP_BASE} + 64'(SP_BYTES)) begin
            r.region = REG_SP;
            r.offset = {32'd0, pa - SP_BASE};
            return r;
        end
        // lowest valid index wins, page offset compared unsigned with wrap
        for (int i = 0; i < N_ENTRIES; i++) begin
            if (tbl_valid[i]) begin
                off = va - tbl_vbase[i];
                if (off < tbl_size[i]) begin
                    r.region = REG_TABLE;
                    r.offset = {32'd0, {8'd0, tbl_pbase[i]} + off} & (span - 64'd1);
                    return r;
                end
            end
        end
        r.region = REG_FALLBACK;
        r.offset = addr - FALLBACK_SUB;
        return r;
    endfunction

    // offer one beat, wait for it to be taken, then update the table copy
    task automatic send_beat(input logic [1:0] cmd, input logic [63:0] addr,
                             input logic [4:0] idx, input logic [31:0] mask,
                             input logic [31:0] virt, input logic [31:0] phys);
        int          gap;
        int          r;
        int          slot;
        logic [31:0] wrapped;
        logic [31:0] size;
        gap = 0;
        if (in_idle_en) begin
            r = $urandom_range(0, 99);
            if (r >= 95)
                gap = $urandom_range(8, 25);
            else if (r >= 60)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_command      <= cmd;
        i_address      <= addr;
        i_entry_index  <= idx;
        i_page_mask    <= mask;
        i_map_virtual  <= virt;
        i_map_physical <= phys;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        // beat taken at this edge
        slot = int'(idx) % N_ENTRIES;
        case (cmd)
            CMD_MAP: begin
                // page size wraps in 32 bits, an all-ones mask gives size zero
                wrapped         = (mask | MASK_FLOOR) + 32'd1;
                size            = wrapped >> 1;
                tbl_valid[slot] = 1'b1;
                tbl_size[slot]  = size;
                tbl_vbase[slot] = virt & ~(size - 32'd1);
                tbl_pbase[slot] = phys[23:0];
                n_map++;
            end
            CMD_UNMAP: begin
                tbl_valid[slot] = 1'b0;
                tbl_vbase[slot] = 32'd0;
                tbl_pbase[slot] = 24'd0;
                tbl_size[slot]  = DEFAULT_PAGE;
                n_unmap++;
            end
            CMD_TRANSLATE: begin
                pending_results.push_back(translate_addr(addr));
                n_translate++;
            end
            default: n_ignored++;
        endcase
    endtask

    // window edges, sp edges, fallback extremes and the dropped command
    task automatic test_fixed_windows();
        send_beat(CMD_TRANSLATE, 64'h0000_0000_8000_0000, 5'd0, 32'd0, 32'd0, 32'd0);
        send_beat(CMD_TRANSLATE, 64'hFFFF_FFFF_807F_FFFF, 5'd0, 32'd0, 32'd0, 32'd0);
        send_beat(CMD_TRANSLATE, 64'h0000_0000_8080_0000, 5'd0, 32'd0, 32'd0, 32'd0);
        send_beat(CMD_TRANSLATE, 64'h1234_5678_A000_0000, 5'd0, 32'd0, 32'd0, 32'd0);
        send_beat(CMD_TRANSLATE, 64'hFFFF_FFFF_A07F_FFFF, 5'd0, 32'd0, 32'd0, 32'd0);
        send_beat(CMD_TRANSLATE, 64'h0000_0000_A080_0000, 5'd0, 32'd0, 32'd0, 32'd0);
        send_beat(CMD_TRANSLATE, 64'h0000_0000_0400_0000, 5'd0, 32'd0, 32'd0, 32'd0);
        // past the uncached window, so the sp window catches it
        send_beat(CMD_TRANSLATE, 64'hFFFF_FFFF_A400_1FFF, 5'd0, 32'd0, 32'd0, 32'd0);
        send_beat(CMD_TRANSLATE, 64'h0000_0000_0400_2000, 5'd0, 32'd0, 32'd0, 32'd0);
        send_beat(CMD_TRANSLATE, 64'hFFFF_FFFF_FFFF_FFFF, 5'd0, 32'd0, 32'd0, 32'd0);
        send_beat(CMD_TRANSLATE, 64'h0, 5'd0, 32'd0, 32'd0, 32'd0);
        // reserved command must leave no trace
        send_beat(CMD_RESERVED, 64'h0000_0000_8000_0000, 5'd2, 32'd0,
                  32'h8000_0000, 32'hFFFF_FFFF);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // map, priority among overlapping entries, zero-size page, unmap
    task automatic test_table_entries();
        send_beat(CMD_MAP, 64'h0, 5'd0, 32'h0000_0000, 32'h0040_1234, 32'hFF12_3456);
        send_beat(CMD_TRANSLATE, 64'h0000_0000_0040_1000, 5'd0, 32'd0, 32'd0, 32'd0);
        send_beat(CMD_TRANSLATE, 64'hFFFF_FFFF_0040_1FFF, 5'd0, 32'd0, 32'd0, 32'd0);
        send_beat(CMD_TRANSLATE, 64'h0000_0000_0040_2000, 5'd0, 32'd0, 32'd0, 32'd0);
        // all-ones mask: size wraps to zero and the entry can never hit
        send_beat(CMD_MAP, 64'h0, 5'd31, 32'hFFFF_FFFF, 32'h1234_5678, 32'h00AB_CDEF);
        send_beat(CMD_TRANSLATE, 64'h0, 5'd0, 32'd0, 32'd0, 32'd0);
        // 64 KiB page under entry 0, lower index must win where both cover
        send_beat(CMD_MAP, 64'h0, 5'd3, 32'h0001_E000, 32'h0040_0000, 32'h00FF_FFFF);
        send_beat(CMD_TRANSLATE, 64'h0000_0000_0040_1800, 5'd0, 32'd0, 32'd0, 32'd0);
        send_beat(CMD_TRANSLATE, 64'h0000_0000_0040_0000, 5'd0, 32'd0, 32'd0, 32'd0);
        send_beat(CMD_UNMAP, 64'h0, 5'd0, 32'd0, 32'd0, 32'd0);
        send_beat(CMD_TRANSLATE, 64'h0000_0000_0040_1800, 5'd0, 32'd0, 32'd0, 32'd0);
        // largest page, base aligns down to 0xc0000000
        send_beat(CMD_MAP, 64'h0, 5'd7, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0012_0000);
        send_beat(CMD_TRANSLATE, 64'h0000_0000_FFFF_FFFF, 5'd0, 32'd0, 32'd0, 32'd0);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // receiver holds off long enough for the block to fill and stall its input
    task automatic test_output_backpressure();
        hold_out = 1'b1;
        for (int n = 0; n < 30; n++) begin
            send_beat(CMD_TRANSLATE,
                      (n % 3 == 0) ? {32'd0, KSEG0_BASE | 32'(n)}
                                   : {$urandom, $urandom_range(0, 32'h00FF_FFFF)},
                      5'd0, 32'd0, 32'd0, 32'd0);
        end
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (hold_out) @(posedge i_clk);
    endtask

    // mostly lookups, many aimed at mapped pages, mixed with page maps, windows and noise
    task automatic test_random_traffic();
        int          issued;
        int          seg;
        int          r;
        int          k;
        int          slot;
        logic [1:0]  cmd;
        logic [4:0]  idx;
        logic [31:0] mask;
        logic [31:0] virt;
        logic [31:0] va;
        logic [31:0] sz;
        logic [31:0] hi;
        issued = 0;
        seg    = 0;
        while (issued < RANDOM_BEATS) begin
            // idling pattern changes every segment, including fully busy stretches
            case (seg % 4)
                0: begin in_idle_en = 1'b1; out_idle_en = 1'b1; end
                1: begin in_idle_en = 1'b0; out_idle_en = 1'b0; end
                2: begin in_idle_en = 1'b1; out_idle_en = 1'b0; end
                default: begin in_idle_en = 1'b0; out_idle_en = 1'b1; end
            endcase
            seg++;
            for (int n = 0; n < SEGMENT_BEATS && issued < RANDOM_BEATS; n++) begin
                r = $urandom_range(0, 99);
                if (r < 1)
                    cmd = CMD_RESERVED;
                else if (r < 12)
                    cmd = CMD_MAP;
                else if (r < 16)
                    cmd = CMD_UNMAP;
                else
                    cmd = CMD_TRANSLATE;
                // low slots get most maps so index priority is exercised
                idx = ($urandom_range(0, 1) == 0) ? 5'($urandom_range(0, 7))
                                                  : 5'($urandom_range(0, 31));
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: begin
                        k    = $urandom_range(13, 26);
                        mask = (32'd1 << k) - 32'd1;
                    end
                    6, 7: mask = $urandom;
                    8: mask = 32'hFFFF_FFFF;
                    default: mask = $urandom & 32'h0000_FFFF;
                endcase
                case ($urandom_range(0, 3))
                    0, 1: virt = $urandom_range(0, 32'h00FF_FFFF);
                    2: virt = 32'hC000_0000 | ($urandom & 32'h00FF_FFFF);
                    default: virt = $urandom;
                endcase
                // lookup address
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    slot = $urandom_range(0, N_ENTRIES - 1);
                    sz   = tbl_size[slot];
                    if (sz == 32'd0)
                        va = $urandom;
                    else if ($urandom_range(0, 4) != 0)
                        va = tbl_vbase[slot] + ($urandom % sz);
                    else
                        va = tbl_vbase[slot] + sz - 32'd2 + 32'($urandom_range(0, 3));
                end else if (r < 60) begin
                    va = ($urandom_range(0, 1) ? KSEG1_BASE : KSEG0_BASE) +
                         32'($urandom_range(0, 32'h0080_0010));
                end else if (r < 70) begin
                    va = ($urandom & ~PHYS_MASK) |
                         (SP_BASE - 32'd4 + 32'($urandom_range(0, SP_BYTES + 8)));
                end else begin
                    va = $urandom;
                end
                case ($urandom_range(0, 2))
                    0: hi = 32'd0;
                    1: hi = 32'hFFFF_FFFF;
                    default: hi = $urandom;
                endcase
                send_beat(cmd, {hi, va}, idx, mask, virt, $urandom);
                if (cmd != CMD_RESERVED)
                    issued++;
            end
        end
        i_in_valid <= 1'b0;
        in_idle_en  = 1'b1;
        out_idle_en = 1'b1;
    endtask

    // receiver side: random stalls, a long hold when a test asks for one
    initial begin
        int left;
        int r;
        left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_out) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
                hold_out = 1'b0;
                left     = 0;
            end else if (!out_idle_en) begin
                i_out_stall <= 1'b0;
            end else if (left > 0) begin
                left--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    i_out_stall <= 1'b0;
                    left = $urandom_range(0, 4);
                end else if (r < 95) begin
                    i_out_stall <= 1'b1;
                    left = $urandom_range(0, 2);
                end else begin
                    i_out_stall <= 1'b1;
                    left = $urandom_range(8, 30);
                end
            end
        end
    end

    // every result beat is matched against the oldest expected translation
    always @(posedge i_clk) begin
        t_xlat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat, region %0d offset %h",
                         $time, o_region, o_offset);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                region_hits[want.region]++;
                if (o_region !== want.region) begin
                    $display("%0t: region mismatch, expected %0d actual %0d",
                             $time, want.region, o_region);
                    err_count++;
                end
                if (o_offset !== want.offset) begin
                    $display("%0t: offset mismatch, expected %h actual %h",
                             $time, want.offset, o_offset);
                    err_count++;
                end
            end
        end
    end

    // hard stop in case the block hangs
    initial begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        for (int i = 0; i < N_ENTRIES; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_vbase[i] = 32'd0;
            tbl_pbase[i] = 24'd0;
            tbl_size[i]  = DEFAULT_PAGE;
        end
        err_count   = 0;
        n_translate = 0;
        n_map       = 0;
        n_unmap     = 0;
        n_ignored   = 0;
        n_checked   = 0;
        for (int i = 0; i < 4; i++) region_hits[i] = 0;
        in_idle_en  = 1'b1;
        out_idle_en = 1'b1;
        hold_out    = 1'b0;

        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_command      <= CMD_TRANSLATE;
        i_address      <= 64'd0;
        i_entry_index  <= 5'd0;
        i_page_mask    <= 32'd0;
        i_map_virtual  <= 32'd0;
        i_map_physical <= 32'd0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_fixed_windows();
        test_table_entries();
        test_output_backpressure();
        test_random_traffic();

        // let the last translations come out, then a quiet drain period
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("beats taken: %0d translate, %0d map, %0d unmap, %0d reserved dropped",
                 n_translate, n_map, n_unmap, n_ignored);
        $display("results checked: %0d (rdram %0d, sp %0d, table %0d, fallback %0d)",
                 n_checked, region_hits[REG_RDRAM], region_hits[REG_SP],
                 region_hits[REG_TABLE], region_hits[REG_FALLBACK]);
        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== kseg_and_tlb_address_translator.f =====
src/kta_pkg.sv
src/kta_front.sv
src/kta_fifo.sv
src/kta_back.sv
src/kseg_and_tlb_address_translator.sv
bench/tb.sv
